// ----- sv/sma_pkg.sv -----
// Shared types and constants for the stack machine ALU unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package sma_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_W      = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH) + 1;
   localparam int DIV_CNT_W   = $clog2(DATA_W);

   typedef enum logic [4:0] {
      OP_PUSH   = 5'd0,  OP_ADD    = 5'd1,  OP_SUB    = 5'd2,  OP_MUL  = 5'd3,
      OP_DIV    = 5'd4,  OP_MOD    = 5'd5,  OP_NEG    = 5'd6,  OP_AND  = 5'd7,
      OP_OR     = 5'd8,  OP_XOR    = 5'd9,  OP_NOT    = 5'd10, OP_DUP  = 5'd11,
      OP_SWAP   = 5'd12, OP_DROP   = 5'd13, OP_PICK   = 5'd14, OP_ROT  = 5'd15,
      OP_EQ     = 5'd16, OP_GT     = 5'd17, OP_LT     = 5'd18, OP_EQ0  = 5'd19,
      OP_GT0    = 5'd20, OP_LT0    = 5'd21, OP_SETF   = 5'd22, OP_CLRF = 5'd23,
      OP_DEPTH  = 5'd24
   } op_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_UNDER = 3'd1,
      ST_OVER  = 3'd2,
      ST_ZDIV  = 3'd3,
      ST_PICK  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RD1, S_RD2, S_RD3, S_PCAP, S_MUL, S_DIV, S_EVAL, S_WR, S_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_TOP1, RD_TOP2, RD_TOP3, RD_PICK
   } rd_sel_type;

   typedef enum logic [1:0] {
      CAP_NONE, CAP_B, CAP_A, CAP_X
   } cap_sel_type;

   typedef struct packed {
      logic        load;
      rd_sel_type  rd_sel;
      cap_sel_type cap_sel;
      logic        arith_init;
      logic        mul_step;
      logic        div_step;
      logic        eval;
      logic        wr_step;
      logic        commit;
   } cmd_type;

   typedef struct packed {
      logic go_pick;
      logic go_mul;
      logic go_div;
      logic mul_done;
      logic div_done;
      logic wr_done;
      logic out_free;
   } stat_type;

endpackage

// ----- sv/sma_ctrl.sv -----
// Sequencing state machine of the stack machine ALU unit.
// Depends on sma_pkg; drives the datapath through sma_pkg::cmd_type.
module sma_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sma_pkg::stat_type stat,
   output sma_pkg::cmd_type  cmd
);

   sma_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sma_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sma_pkg::S_IDLE: if (req_valid) state_in = sma_pkg::S_RD1;
         sma_pkg::S_RD1:  state_in = sma_pkg::S_RD2;
         sma_pkg::S_RD2:  state_in = sma_pkg::S_RD3;
         sma_pkg::S_RD3: begin
            if (stat.go_pick) state_in = sma_pkg::S_PCAP;
            else if (stat.go_mul) state_in = sma_pkg::S_MUL;
            else if (stat.go_div) state_in = sma_pkg::S_DIV;
            else state_in = sma_pkg::S_EVAL;
         end
         sma_pkg::S_PCAP: state_in = sma_pkg::S_EVAL;
         sma_pkg::S_MUL:  if (stat.mul_done) state_in = sma_pkg::S_EVAL;
         sma_pkg::S_DIV:  if (stat.div_done) state_in = sma_pkg::S_EVAL;
         sma_pkg::S_EVAL: state_in = sma_pkg::S_WR;
         sma_pkg::S_WR:   if (stat.wr_done) state_in = sma_pkg::S_DONE;
         sma_pkg::S_DONE: if (stat.out_free) state_in = sma_pkg::S_IDLE;
         default:         state_in = sma_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.rd_sel     = sma_pkg::RD_TOP1;
      cmd.cap_sel    = sma_pkg::CAP_NONE;
      req_ready      = 1'b0;
      unique case (state_ff)
         sma_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         sma_pkg::S_RD1: begin
            cmd.rd_sel  = sma_pkg::RD_TOP2;
            cmd.cap_sel = sma_pkg::CAP_B;
         end
         sma_pkg::S_RD2: begin
            cmd.rd_sel  = sma_pkg::RD_TOP3;
            cmd.cap_sel = sma_pkg::CAP_A;
         end
         sma_pkg::S_RD3: begin
            cmd.rd_sel     = sma_pkg::RD_PICK;
            cmd.cap_sel    = sma_pkg::CAP_X;
            cmd.arith_init = 1'b1;
         end
         sma_pkg::S_PCAP: cmd.cap_sel = sma_pkg::CAP_X;
         sma_pkg::S_MUL:  cmd.mul_step = 1'b1;
         sma_pkg::S_DIV:  cmd.div_step = 1'b1;
         sma_pkg::S_EVAL: cmd.eval = 1'b1;
         sma_pkg::S_WR:   cmd.wr_step = 1'b1;
         sma_pkg::S_DONE: cmd.commit = stat.out_free;
         default: ;
      endcase
   end

endmodule

// ----- sv/sma_dpath.sv -----
// Datapath of the stack machine ALU unit: stack memory, operand registers,
// shared multiplier, bit-serial divider, result evaluation and output register.
// Depends on sma_pkg; controlled by sma_ctrl.
module sma_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [4:0]                         req_mode,
   input  logic signed [sma_pkg::DATA_W-1:0]  req_literal,
   input  sma_pkg::cmd_type                   cmd,
   output sma_pkg::stat_type                  stat,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [sma_pkg::DATA_W-1:0]  rsp_top_value,
   output logic                               rsp_truth_flag,
   output logic [sma_pkg::CNT_W-1:0]          rsp_stack_count,
   output logic [2:0]                         rsp_status
);

   localparam int DW = sma_pkg::DATA_W;
   localparam int AW = sma_pkg::ADDR_W;
   localparam int CW = sma_pkg::CNT_W;
   localparam int HW = DW / 2;
   localparam int DIV_CNT_W_L = sma_pkg::DIV_CNT_W;

   function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
      mag = v[DW-1] ? (~v + 1'b1) : v;
   endfunction

   logic [DW-1:0]  mem [sma_pkg::STACK_DEPTH];
   logic [DW-1:0]  rd_ff;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [DW-1:0]  wr_data;

   logic [CW-1:0]  count_ff;
   logic           flag_ff;
   sma_pkg::op_type mode_ff;
   logic [DW-1:0]  lit_ff, a_ff, b_ff, x_ff;

   logic [1:0]     mcnt_ff;
   logic [DW-1:0]  mp_ff, acc_ff;
   logic [HW-1:0]  mul_l, mul_r;

   logic [DIV_CNT_W_L-1:0] dcnt_ff;
   logic [DW-1:0]  dq_ff, dr_ff, dd_ff;
   logic [DW:0]    trial;

   logic [AW-1:0]  wa_ff [3];
   logic [DW-1:0]  wd_ff [3];
   logic [1:0]     nwr_ff, wcnt_ff;
   sma_pkg::status_type st_ff;
   logic [CW-1:0]  ncnt_ff;
   logic           nflag_ff;
   logic [DW-1:0]  ntop_ff;

   logic           rsp_valid_ff;
   logic [DW-1:0]  rsp_top_ff;
   logic           rsp_flag_ff;
   logic [CW-1:0]  rsp_cnt_ff;
   sma_pkg::status_type rsp_st_ff;

   // Evaluation results.
   sma_pkg::status_type e_st;
   logic [CW-1:0]  e_cnt;
   logic           e_flag;
   logic [DW-1:0]  e_top, e_res, quot, remd;
   logic [1:0]     e_nwr;
   logic [AW-1:0]  e_wa [3];
   logic [DW-1:0]  e_wd [3];

   // Stack memory: one write and one registered read per cycle.
   always_comb begin
      case (cmd.rd_sel)
         sma_pkg::RD_TOP1: rd_addr = AW'(count_ff - CW'(1));
         sma_pkg::RD_TOP2: rd_addr = AW'(count_ff - CW'(2));
         sma_pkg::RD_TOP3: rd_addr = AW'(count_ff - CW'(3));
         default:          rd_addr = AW'(count_ff - CW'(1) - b_ff[CW-1:0]);
      endcase
   end

   assign wr_en   = cmd.wr_step && (wcnt_ff != nwr_ff);
   assign wr_addr = wa_ff[wcnt_ff];
   assign wr_data = wd_ff[wcnt_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // Operand capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= sma_pkg::op_type'(req_mode);
         lit_ff  <= req_literal;
      end
      case (cmd.cap_sel)
         sma_pkg::CAP_B: b_ff <= rd_ff;
         sma_pkg::CAP_A: a_ff <= rd_ff;
         sma_pkg::CAP_X: x_ff <= rd_ff;
         default: ;
      endcase
   end

   // 64-bit wrapped product from three 32x32 partial products on one multiplier.
   always_comb begin
      case (mcnt_ff)
         2'd0:    begin mul_l = a_ff[HW-1:0];  mul_r = b_ff[HW-1:0];  end
         2'd1:    begin mul_l = a_ff[HW-1:0];  mul_r = b_ff[DW-1:HW]; end
         default: begin mul_l = a_ff[DW-1:HW]; mul_r = b_ff[HW-1:0];  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.arith_init) begin
         mcnt_ff <= '0;
         acc_ff  <= '0;
      end else if (cmd.mul_step) begin
         mcnt_ff <= mcnt_ff + 2'd1;
         if (mcnt_ff != 2'd3) begin
            mp_ff <= mul_l * mul_r;
         end
         if (mcnt_ff == 2'd1) begin
            acc_ff <= acc_ff + mp_ff;
         end else if (mcnt_ff != 2'd0) begin
            acc_ff <= acc_ff + {mp_ff[HW-1:0], {HW{1'b0}}};
         end
      end
   end

   // Restoring division on magnitudes, one quotient bit per cycle.
   assign trial = {dr_ff, dq_ff[DW-1]} - {1'b0, dd_ff};

   always_ff @(posedge clock) begin
      if (cmd.arith_init) begin
         dq_ff   <= mag(a_ff);
         dd_ff   <= mag(b_ff);
         dr_ff   <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         if (!trial[DW]) begin
            dr_ff <= trial[DW-1:0];
            dq_ff <= {dq_ff[DW-2:0], 1'b1};
         end else begin
            dr_ff <= {dr_ff[DW-2:0], dq_ff[DW-1]};
            dq_ff <= {dq_ff[DW-2:0], 1'b0};
         end
      end
   end

   assign quot = (a_ff[DW-1] ^ b_ff[DW-1]) ? (~dq_ff + 1'b1) : dq_ff;
   assign remd = a_ff[DW-1] ? (~dr_ff + 1'b1) : dr_ff;

   // Outcome of the primitive, written back in the following cycles.
   always_comb begin
      e_st   = sma_pkg::ST_OK;
      e_cnt  = count_ff;
      e_flag = flag_ff;
      e_top  = b_ff;
      e_nwr  = 2'd0;
      e_res  = '0;
      for (int i = 0; i < 3; i++) begin
         e_wa[i] = '0;
         e_wd[i] = '0;
      end
      unique case (mode_ff)
         sma_pkg::OP_PUSH, sma_pkg::OP_DEPTH: begin
            if (count_ff >= CW'(sma_pkg::STACK_DEPTH)) begin
               e_st = sma_pkg::ST_OVER;
            end else begin
               e_res = (mode_ff == sma_pkg::OP_PUSH) ? lit_ff : DW'(count_ff);
               e_nwr = 2'd1;
               e_wa[0] = AW'(count_ff);
               e_wd[0] = e_res;
               e_cnt = count_ff + CW'(1);
               e_top = e_res;
            end
         end
         sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MUL, sma_pkg::OP_DIV,
         sma_pkg::OP_MOD, sma_pkg::OP_AND, sma_pkg::OP_OR, sma_pkg::OP_XOR: begin
            case (mode_ff)
               sma_pkg::OP_ADD: e_res = a_ff + b_ff;
               sma_pkg::OP_SUB: e_res = a_ff - b_ff;
               sma_pkg::OP_MUL: e_res = acc_ff;
               sma_pkg::OP_DIV: e_res = quot;
               sma_pkg::OP_MOD: e_res = remd;
               sma_pkg::OP_AND: e_res = a_ff & b_ff;
               sma_pkg::OP_OR:  e_res = a_ff | b_ff;
               default:         e_res = a_ff ^ b_ff;
            endcase
            if (count_ff < CW'(2)) begin
               e_st = sma_pkg::ST_UNDER;
            end else if ((mode_ff == sma_pkg::OP_DIV || mode_ff == sma_pkg::OP_MOD)
                         && b_ff == '0) begin
               e_st = sma_pkg::ST_ZDIV;
            end else begin
               e_nwr = 2'd1;
               e_wa[0] = AW'(count_ff - CW'(2));
               e_wd[0] = e_res;
               e_cnt = count_ff - CW'(1);
               e_top = e_res;
            end
         end
         sma_pkg::OP_NEG, sma_pkg::OP_NOT: begin
            e_res = (mode_ff == sma_pkg::OP_NEG) ? (~b_ff + 1'b1) : ~b_ff;
            if (count_ff < CW'(1)) begin
               e_st = sma_pkg::ST_UNDER;
            end else begin
               e_nwr = 2'd1;
               e_wa[0] = AW'(count_ff - CW'(1));
               e_wd[0] = e_res;
               e_top = e_res;
            end
         end
         sma_pkg::OP_DUP: begin
            if (count_ff < CW'(1)) begin
               e_st = sma_pkg::ST_UNDER;
            end else if (count_ff >= CW'(sma_pkg::STACK_DEPTH)) begin
               e_st = sma_pkg::ST_OVER;
            end else begin
               e_nwr = 2'd1;
               e_wa[0] = AW'(count_ff);
               e_wd[0] = b_ff;
               e_cnt = count_ff + CW'(1);
            end
         end
         sma_pkg::OP_SWAP: begin
            if (count_ff < CW'(2)) begin
               e_st = sma_pkg::ST_UNDER;
            end else begin
               e_nwr = 2'd2;
               e_wa[0] = AW'(count_ff - CW'(1));
               e_wd[0] = a_ff;
               e_wa[1] = AW'(count_ff - CW'(2));
               e_wd[1] = b_ff;
               e_top = a_ff;
            end
         end
         sma_pkg::OP_DROP: begin
            if (count_ff < CW'(1)) begin
               e_st = sma_pkg::ST_UNDER;
            end else begin
               e_cnt = count_ff - CW'(1);
               e_top = a_ff;
            end
         end
         sma_pkg::OP_PICK: begin
            if (count_ff < CW'(1)) begin
               e_st = sma_pkg::ST_UNDER;
            end else if (b_ff >= DW'(count_ff)) begin
               e_st = sma_pkg::ST_PICK;
            end else begin
               e_nwr = 2'd1;
               e_wa[0] = AW'(count_ff - CW'(1));
               e_wd[0] = x_ff;
               e_top = x_ff;
            end
         end
         sma_pkg::OP_ROT: begin
            if (count_ff < CW'(3)) begin
               e_st = sma_pkg::ST_UNDER;
            end else begin
               e_nwr = 2'd3;
               e_wa[0] = AW'(count_ff - CW'(3));
               e_wd[0] = a_ff;
               e_wa[1] = AW'(count_ff - CW'(2));
               e_wd[1] = b_ff;
               e_wa[2] = AW'(count_ff - CW'(1));
               e_wd[2] = x_ff;
               e_top = x_ff;
            end
         end
         sma_pkg::OP_EQ, sma_pkg::OP_GT, sma_pkg::OP_LT: begin
            if (count_ff < CW'(2)) begin
               e_st = sma_pkg::ST_UNDER;
            end else begin
               if (mode_ff == sma_pkg::OP_EQ) e_flag = (a_ff == b_ff);
               else if (mode_ff == sma_pkg::OP_GT) e_flag = $signed(a_ff) > $signed(b_ff);
               else e_flag = $signed(b_ff) > $signed(a_ff);
               e_cnt = count_ff - CW'(2);
               e_top = x_ff;
            end
         end
         sma_pkg::OP_EQ0, sma_pkg::OP_GT0, sma_pkg::OP_LT0: begin
            if (count_ff < CW'(1)) begin
               e_st = sma_pkg::ST_UNDER;
            end else begin
               if (mode_ff == sma_pkg::OP_EQ0) e_flag = (b_ff == '0);
               else if (mode_ff == sma_pkg::OP_GT0) e_flag = (b_ff != '0) && !b_ff[DW-1];
               else e_flag = b_ff[DW-1];
               e_cnt = count_ff - CW'(1);
               e_top = a_ff;
            end
         end
         sma_pkg::OP_SETF: e_flag = 1'b1;
         sma_pkg::OP_CLRF: e_flag = 1'b0;
         default: ;
      endcase
      if (e_cnt == '0) begin
         e_top = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         st_ff    <= e_st;
         ncnt_ff  <= e_cnt;
         nflag_ff <= e_flag;
         ntop_ff  <= e_top;
         nwr_ff   <= e_nwr;
         wcnt_ff  <= 2'd0;
         for (int i = 0; i < 3; i++) begin
            wa_ff[i] <= e_wa[i];
            wd_ff[i] <= e_wd[i];
         end
      end else if (wr_en) begin
         wcnt_ff <= wcnt_ff + 2'd1;
      end
   end

   // Architectural state and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            count_ff     <= ncnt_ff;
            flag_ff      <= nflag_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_top_ff  <= ntop_ff;
         rsp_flag_ff <= nflag_ff;
         rsp_cnt_ff  <= ncnt_ff;
         rsp_st_ff   <= st_ff;
      end
   end

   assign stat.go_pick  = (mode_ff == sma_pkg::OP_PICK) && (count_ff != '0);
   assign stat.go_mul   = (mode_ff == sma_pkg::OP_MUL) && (count_ff >= CW'(2));
   assign stat.go_div   = (mode_ff == sma_pkg::OP_DIV || mode_ff == sma_pkg::OP_MOD)
                          && (count_ff >= CW'(2)) && (b_ff != '0);
   assign stat.mul_done = (mcnt_ff == 2'd3);
   assign stat.div_done = (dcnt_ff == DIV_CNT_W_L'(DW - 1));
   assign stat.wr_done  = (wcnt_ff == nwr_ff);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_value   = rsp_top_ff;
   assign rsp_truth_flag  = rsp_flag_ff;
   assign rsp_stack_count = rsp_cnt_ff;
   assign rsp_status      = rsp_st_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(sma_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");
   a_over_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_st_ff == sma_pkg::ST_OVER
      |-> rsp_cnt_ff == CW'(sma_pkg::STACK_DEPTH))
      else $error("overflow reported on a stack that is not full");
   a_under_small: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_st_ff == sma_pkg::ST_UNDER |-> rsp_cnt_ff < CW'(3))
      else $error("underflow reported on a deep stack");
   a_commit_keeps: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> count_ff == $past(count_ff))
      else $error("stack count changed outside commit");
`endif

endmodule

// ----- sv/stack_machine_alu_unit.sv -----
// Top level of the stack machine ALU unit.
// Depends on sma_pkg, sma_ctrl and sma_dpath.
// The unit takes one item at a time. Each item reads up to three stack cells
// and the pick target serially through the single read port of the stack
// memory, then writes up to three cells back one per cycle. Multiply also
// forms its partial products on one 32x32 multiplier, and divide or modulo
// runs the bit-serial divider, before the writes. A new item is accepted
// once the previous result has been loaded into the output register.
module stack_machine_alu_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [4:0]                         req_mode,
   input  logic signed [sma_pkg::DATA_W-1:0]  req_literal,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [sma_pkg::DATA_W-1:0]  rsp_top_value,
   output logic                               rsp_truth_flag,
   output logic [sma_pkg::CNT_W-1:0]          rsp_stack_count,
   output logic [2:0]                         rsp_status
);

   sma_pkg::cmd_type  cmd;
   sma_pkg::stat_type stat;

   sma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sma_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_literal     (req_literal),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_top_value   (rsp_top_value),
      .rsp_truth_flag  (rsp_truth_flag),
      .rsp_stack_count (rsp_stack_count),
      .rsp_status      (rsp_status)
   );

endmodule
